// File: sv/cclru_pkg.sv
package cclru_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_ENTRIES_DEF   = 64;
  localparam int PENDING_DEPTH_DEF = 16;

  // Field widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int COORD_W = 16;
  localparam int POP_W   = 31;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 6;

  localparam logic [POP_W-1:0] POP_MAX   = {POP_W{1'b1}};
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_REQ  = 2'd0,
    CMD_INST = 2'd1,
    CMD_POP  = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  // One word of the entry memory
  typedef struct packed {
    logic               valid;
    logic [POP_W-1:0]   pop;
    logic [COORD_W-1:0] tag_z;
    logic [COORD_W-1:0] tag_x;
  } entry_t;

  // One word of the pending miss memory
  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] x;
  } pend_t;

endpackage

// File: sv/chunk_cache_lru_replacement_core.sv
// Chunk cache tag table with least-popular replacement and a pending miss queue.
// Input channel (in_valid/in_stall) carries one command item: request lookup,
// install, pop pending miss or tick. Output channel (out_valid/out_stall)
// returns exactly one result item per command, in order.
// Entries sit in a single-port-write, single-port-read memory with a registered
// read; request, install and tick walk the active entries one address
// per cycle, the count of active entries being entries_in_use clamped to
// MAX_ENTRIES. A request hit at entry i ends the walk early.
// One item is worked on at a time; in_stall is high while an item is at work.
// Once a result moves into the output register the next item can be taken at
// the following edge. A result waits in the output register while out_stall
// is high; a finished result behind it holds in_stall high until the register
// frees up.
// Reset (rst_n low, synchronous) empties the pending queue, sets
// entries_in_use to 64 and starts a clearing pass over the entry memory,
// one entry per cycle, with in_stall high.
// cfg_wr_en writes entries_in_use at any edge; write it only while idle.
module chunk_cache_lru_replacement_core #(
  parameter int MAX_ENTRIES   = cclru_pkg::MAX_ENTRIES_DEF,
  parameter int PENDING_DEPTH = cclru_pkg::PENDING_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [cclru_pkg::CFG_W-1:0]          cfg_wr_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cclru_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [cclru_pkg::COORD_W-1:0] in_chunk_x,
  input  logic signed [cclru_pkg::COORD_W-1:0] in_chunk_z,
  input  logic [cclru_pkg::POP_W-1:0]          in_now_time,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit,
  output logic [cclru_pkg::IDX_W-1:0]          out_entry_index,
  output logic                                 out_miss_queued,
  output logic                                 out_miss_dropped,
  output logic                                 out_pend_valid,
  output logic signed [cclru_pkg::COORD_W-1:0] out_pend_x,
  output logic signed [cclru_pkg::COORD_W-1:0] out_pend_z
);

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int NBW  = $clog2(MAX_ENTRIES + 1);
  localparam int CNTW = (NBW > cclru_pkg::CFG_W) ? NBW : cclru_pkg::CFG_W;
  localparam int PW   = $clog2(PENDING_DEPTH);
  localparam int PCW  = $clog2(PENDING_DEPTH + 1);

  localparam logic [IW-1:0]   LAST_ENTRY = IW'(MAX_ENTRIES - 1);
  localparam logic [CNTW-1:0] MAX_CNT    = CNTW'(MAX_ENTRIES);
  localparam logic [PW-1:0]   LAST_SLOT  = PW'(PENDING_DEPTH - 1);
  localparam logic [PCW-1:0]  FULL_CNT   = PCW'(PENDING_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_POP,
    S_FIN
  } state_t;

  // Memories
  cclru_pkg::entry_t ent_mem [MAX_ENTRIES];
  cclru_pkg::pend_t  pend_mem [PENDING_DEPTH];

  cclru_pkg::entry_t ent_rdata_r;
  cclru_pkg::entry_t ent_wdata;
  logic [IW-1:0]     ent_raddr;
  logic [IW-1:0]     ent_waddr;
  logic              ent_we;

  cclru_pkg::pend_t  pend_rdata_r;
  cclru_pkg::pend_t  pend_wdata;
  logic              pend_we;

  // Control and item registers
  state_t                         state_r, state_nxt;
  logic [cclru_pkg::CFG_W-1:0]    cfg_r, cfg_nxt;
  logic [IW-1:0]                  clr_r, clr_nxt;
  cclru_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [cclru_pkg::COORD_W-1:0]  x_r, x_nxt;
  logic [cclru_pkg::COORD_W-1:0]  z_r, z_nxt;
  logic [cclru_pkg::POP_W-1:0]    now_r, now_nxt;
  logic [CNTW-1:0]                iss_r, iss_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]                  rd_idx_r, rd_idx_nxt;
  logic [cclru_pkg::POP_W-1:0]    lowest_r, lowest_nxt;
  logic [IW-1:0]                  victim_r, victim_nxt;
  logic [PW-1:0]                  head_r, head_nxt;
  logic [PW-1:0]                  tail_r, tail_nxt;
  logic [PCW-1:0]                 count_r, count_nxt;

  // Pending result
  logic                           res_hit_r, res_hit_nxt;
  logic [IW-1:0]                  res_idx_r, res_idx_nxt;
  logic                           res_mq_r, res_mq_nxt;
  logic                           res_md_r, res_md_nxt;
  logic                           res_pv_r, res_pv_nxt;
  logic [cclru_pkg::COORD_W-1:0]  res_px_r, res_px_nxt;
  logic [cclru_pkg::COORD_W-1:0]  res_pz_r, res_pz_nxt;

  // Output register
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_hit_r, out_hit_nxt;
  logic [cclru_pkg::IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                           out_mq_r, out_mq_nxt;
  logic                           out_md_r, out_md_nxt;
  logic                           out_pv_r, out_pv_nxt;
  logic [cclru_pkg::COORD_W-1:0]  out_px_r, out_px_nxt;
  logic [cclru_pkg::COORD_W-1:0]  out_pz_r, out_pz_nxt;

  logic [CNTW-1:0]                cfg_ext;
  logic [CNTW-1:0]                n_act;
  logic                           issue;
  logic                           tag_match;
  logic [IW+cclru_pkg::IDX_W-1:0] res_idx_ext;

  // Active entry count, clamped to the table size
  assign cfg_ext = CNTW'(cfg_r);
  assign n_act   = (cfg_ext > MAX_CNT) ? MAX_CNT : cfg_ext;

  assign issue     = (state_r == S_SCAN) && (iss_r < n_act);
  assign ent_raddr = iss_r[IW-1:0];
  assign tag_match = ent_rdata_r.valid && (ent_rdata_r.tag_x == x_r) &&
                     (ent_rdata_r.tag_z == z_r);
  assign res_idx_ext = {{cclru_pkg::IDX_W{1'b0}}, res_idx_r};

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_entry_index  = out_idx_r;
  assign out_miss_queued  = out_mq_r;
  assign out_miss_dropped = out_md_r;
  assign out_pend_valid   = out_pv_r;
  assign out_pend_x       = out_px_r;
  assign out_pend_z       = out_pz_r;

  // Next-state logic
  always_comb begin
    state_nxt   = state_r;
    cfg_nxt     = cfg_wr_en ? cfg_wr_data : cfg_r;
    clr_nxt     = clr_r;
    cmd_nxt     = cmd_r;
    x_nxt       = x_r;
    z_nxt       = z_r;
    now_nxt     = now_r;
    iss_nxt     = iss_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    lowest_nxt  = lowest_r;
    victim_nxt  = victim_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    res_hit_nxt = res_hit_r;
    res_idx_nxt = res_idx_r;
    res_mq_nxt  = res_mq_r;
    res_md_nxt  = res_md_r;
    res_pv_nxt  = res_pv_r;
    res_px_nxt  = res_px_r;
    res_pz_nxt  = res_pz_r;
    ent_we      = 1'b0;
    ent_waddr   = rd_idx_r;
    ent_wdata   = ent_rdata_r;
    pend_we     = 1'b0;
    pend_wdata  = '{x: x_r, z: z_r};

    // output register drains on handshake
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_idx_nxt   = out_idx_r;
    out_mq_nxt    = out_mq_r;
    out_md_nxt    = out_md_r;
    out_pv_nxt    = out_pv_r;
    out_px_nxt    = out_px_r;
    out_pz_nxt    = out_pz_r;

    unique case (state_r)
      S_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_r;
        ent_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_ENTRY) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = cclru_pkg::cmd_t'(in_cmd);
          x_nxt       = in_chunk_x;
          z_nxt       = in_chunk_z;
          now_nxt     = in_now_time;
          iss_nxt     = '0;
          lowest_nxt  = cclru_pkg::POP_MAX;
          victim_nxt  = '0;
          res_hit_nxt = 1'b0;
          res_idx_nxt = '0;
          res_mq_nxt  = 1'b0;
          res_md_nxt  = 1'b0;
          res_pv_nxt  = 1'b0;
          res_px_nxt  = '0;
          res_pz_nxt  = '0;
          state_nxt   = (cclru_pkg::cmd_t'(in_cmd) == cclru_pkg::CMD_POP) ? S_POP : S_SCAN;
        end
      end

      S_SCAN: begin
        // one read issued per cycle, data checked in the following cycle
        if (issue) begin
          iss_nxt    = iss_r + 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = iss_r[IW-1:0];
        end
        if (rd_vld_r) begin
          case (cmd_r)
            cclru_pkg::CMD_REQ: begin
              if (tag_match) begin
                ent_we        = 1'b1;
                ent_wdata.pop = now_r;
                res_hit_nxt   = 1'b1;
                res_idx_nxt   = rd_idx_r;
                rd_vld_nxt    = 1'b0;
                state_nxt     = S_FIN;
              end
            end
            cclru_pkg::CMD_INST: begin
              if (ent_rdata_r.pop < lowest_r) begin
                lowest_nxt = ent_rdata_r.pop;
                victim_nxt = rd_idx_r;
              end
            end
            cclru_pkg::CMD_TICK: begin
              if (ent_rdata_r.pop != cclru_pkg::POP_MAX) begin
                ent_we        = 1'b1;
                ent_wdata.pop = ent_rdata_r.pop + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if (!issue) begin
          // walk finished
          state_nxt = S_FIN;
          case (cmd_r)
            cclru_pkg::CMD_REQ: begin
              if (count_r < FULL_CNT) begin
                pend_we    = 1'b1;
                tail_nxt   = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
                count_nxt  = count_r + 1'b1;
                res_mq_nxt = 1'b1;
              end else begin
                res_md_nxt = 1'b1;
              end
            end
            cclru_pkg::CMD_INST: begin
              ent_we      = 1'b1;
              ent_waddr   = victim_r;
              ent_wdata   = '{valid: 1'b1, pop: now_r, tag_z: z_r, tag_x: x_r};
              res_idx_nxt = victim_r;
            end
            default: begin
            end
          endcase
        end
      end

      S_POP: begin
        // pend_rdata_r holds the head slot read at the accept edge
        if (count_r != '0) begin
          res_pv_nxt = 1'b1;
          res_px_nxt = pend_rdata_r.x;
          res_pz_nxt = pend_rdata_r.z;
          head_nxt   = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
          count_nxt  = count_r - 1'b1;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_idx_nxt   = res_idx_ext[cclru_pkg::IDX_W-1:0];
          out_mq_nxt    = res_mq_r;
          out_md_nxt    = res_md_r;
          out_pv_nxt    = res_pv_r;
          out_px_nxt    = res_px_r;
          out_pz_nxt    = res_pz_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cfg_r       <= cclru_pkg::CFG_RESET;
      clr_r       <= '0;
      rd_vld_r    <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      clr_r       <= clr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    x_r       <= x_nxt;
    z_r       <= z_nxt;
    now_r     <= now_nxt;
    iss_r     <= iss_nxt;
    rd_idx_r  <= rd_idx_nxt;
    lowest_r  <= lowest_nxt;
    victim_r  <= victim_nxt;
    res_hit_r <= res_hit_nxt;
    res_idx_r <= res_idx_nxt;
    res_mq_r  <= res_mq_nxt;
    res_md_r  <= res_md_nxt;
    res_pv_r  <= res_pv_nxt;
    res_px_r  <= res_px_nxt;
    res_pz_r  <= res_pz_nxt;
    out_hit_r <= out_hit_nxt;
    out_idx_r <= out_idx_nxt;
    out_mq_r  <= out_mq_nxt;
    out_md_r  <= out_md_nxt;
    out_pv_r  <= out_pv_nxt;
    out_px_r  <= out_px_nxt;
    out_pz_r  <= out_pz_nxt;
  end

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_r <= ent_mem[ent_raddr];
  end

  // Pending miss memory: push at tail, read at head
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[tail_r] <= pend_wdata;
    end
    pend_rdata_r <= pend_mem[head_r];
  end

endmodule
